// File: rtl/combined_lcg_shuffle_rng_unit_defines.svh
// Assertion macros shared by the checker of the combined LCG shuffle RNG unit.
// No dependencies; include by bare file name.
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clsr_pkg.sv
// Package of the combined LCG shuffle RNG unit: sizes, moduli, control types.
// No dependencies; imported by every module of the block except clsr_ram.
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);

    localparam int DATA_W = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = DATA_W + MUL_W;
    localparam int HI_W   = PROD_W - DATA_W;
    localparam int FOLD_W = 8;
    localparam int SUM_W  = DATA_W + 1;

    localparam logic [DATA_W-1:0] MOD_ONE   = 31'd2147483563;
    localparam logic [DATA_W-1:0] MOD_TWO   = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_ONE   = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_TWO   = 16'd40692;
    // 2^31 mod each modulus
    localparam logic [FOLD_W-1:0] FOLD_ONE  = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_TWO  = 8'd249;
    localparam logic [DATA_W-1:0] WRAP_SPAN = 31'd2147483562;
    localparam logic [DATA_W-1:0] SAT_LIMIT = 31'd2147483305;
    localparam logic [DATA_W-1:0] GEN_ONE_RESET = 31'd1;
    localparam logic [DATA_W-1:0] GEN_TWO_RESET = 31'd123456789;

    localparam longint SLOT_DIV = 1 + 2147483562 / TABLE_DEPTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMUL,
        ST_RRED,
        ST_SETTLE,
        ST_DMUL,
        ST_DRED,
        ST_DOUT
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] addr;
    } tbl_ctrl_t;

    // Lower bound of last_output for slot k.
    function automatic logic [DATA_W-1:0] slot_threshold(input int k);
        longint t;
        t = longint'(k) * SLOT_DIV;
        return t[DATA_W-1:0];
    endfunction

endpackage

// File: rtl/clsr_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module clsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/clsr_table.sv
// Shuffle table: RAM plus per-entry valid bits so unwritten slots read zero.
// Depends on clsr_pkg and clsr_ram.
module clsr_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  clsr_pkg::tbl_ctrl_t          ctrl,
    input  logic [clsr_pkg::DATA_W-1:0]  wdata,
    output logic [clsr_pkg::DATA_W-1:0]  rdata
);
    import clsr_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic                   rd_valid_reg;
    logic [DATA_W-1:0]      ram_q;

    clsr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ctrl.wr_en),
        .re    (ctrl.rd_en),
        .addr  (ctrl.addr),
        .wdata (wdata),
        .rdata (ram_q)
    );

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.wr_en) begin
            valid_next[ctrl.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        if (ctrl.rd_en) begin
            rd_valid_reg <= valid_reg[ctrl.addr];
        end
    end

    assign rdata = rd_valid_reg ? ram_q : '0;

endmodule

// File: rtl/clsr_modmul.sv
// One generator step: x times a constant multiplier, modulo a modulus near 2^31.
// Depends on clsr_pkg. Product is registered; the fold and subtract follow it.
module clsr_modmul (
    input  logic                        aclk,
    input  logic                        sel_two,
    input  logic [clsr_pkg::DATA_W-1:0] x,
    output logic [clsr_pkg::DATA_W-1:0] r
);
    import clsr_pkg::*;

    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W-1:0]           prod_next;
    logic [MUL_W-1:0]            mul_c;
    logic [FOLD_W-1:0]           fold_c;
    logic [DATA_W-1:0]           mod_c;
    logic [HI_W+FOLD_W-1:0]      hi_fold;
    logic [SUM_W-1:0]            sum;
    logic [SUM_W-1:0]            sum_red;

    assign mul_c  = sel_two ? MUL_TWO  : MUL_ONE;
    assign fold_c = sel_two ? FOLD_TWO : FOLD_ONE;
    assign mod_c  = sel_two ? MOD_TWO  : MOD_ONE;

    assign prod_next = PROD_W'(x) * PROD_W'(mul_c);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // hi*2^31 + lo == hi*fold + lo (mod m); sum stays below 2m
    always_comb begin
        hi_fold = (HI_W+FOLD_W)'(prod_reg[PROD_W-1:DATA_W]) * (HI_W+FOLD_W)'(fold_c);
        sum     = SUM_W'(prod_reg[DATA_W-1:0]) + SUM_W'(hi_fold);
        sum_red = (sum >= SUM_W'(mod_c)) ? sum - SUM_W'(mod_c) : sum;
        r       = sum_red[DATA_W-1:0];
    end

endmodule

// File: rtl/clsr_slot.sv
// Slot select: last output divided by the slot divisor, clamped to the top slot.
// Depends on clsr_pkg. Threshold compares are registered, then priority-encoded.
module clsr_slot (
    input  logic                        aclk,
    input  logic [clsr_pkg::DATA_W-1:0] last_output,
    output logic [clsr_pkg::SLOT_W-1:0] slot
);
    import clsr_pkg::*;

    logic [TABLE_DEPTH-2:0] thermo_reg;
    logic [TABLE_DEPTH-2:0] thermo_next;

    always_comb begin
        for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
            thermo_next[k] = (last_output >= slot_threshold(k + 1));
        end
    end

    always_ff @(posedge aclk) begin
        thermo_reg <= thermo_next;
    end

    always_comb begin
        slot = '0;
        for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
            if (thermo_reg[k]) begin
                slot = SLOT_W'(k + 1);
            end
        end
    end

endmodule

// File: rtl/combined_lcg_shuffle_rng_unit.sv
// Combined LCG shuffle RNG unit: two modular generators and a shuffle table in RAM.
// Draw: result and s_tready rise together after DMUL, DRED, DOUT; DOUT stalls on m_tready.
// Reseed: WARM_STEPS warm-up steps (RMUL, RRED), SETTLE, then the draw; one beat at a time.
// Rate is set by the multiply/fold pipeline of each generator step and the table port.
// Reset (aresetn low, synchronous): generators to 1 and 123456789, last output to 0,
// table valid bits cleared so every slot reads zero; s_tready low while in reset.
module combined_lcg_shuffle_rng_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero pad
    input  logic        s_tuser,   // [0] operation: 0 draw, 1 reseed then draw
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] sample, [31] zero pad
);
    import clsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Generator and draw state
    logic [DATA_W-1:0] g1_reg;
    logic [DATA_W-1:0] g2_reg;
    logic [DATA_W-1:0] last_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Output register parts the result beat from the core
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;

    logic [DATA_W-1:0] r1;
    logic [DATA_W-1:0] r2;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] entry;
    logic [DATA_W-1:0] seed_v;
    logic [DATA_W-1:0] res;
    logic [SUM_W-1:0]  res_wrap;
    logic [DATA_W-1:0] sat_v;

    logic              in_fire;
    logic              out_free;
    logic              warm_last;
    logic              warm_store;

    // Control decoded from the state
    logic              ld_seed;
    logic              ld_g1_warm;
    logic              ld_g_draw;
    logic              ld_slot;
    logic              out_load;
    tbl_ctrl_t         tbl_ctrl;
    logic [DATA_W-1:0] tbl_wdata;

    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign warm_last  = (cnt_reg == '0);
    assign warm_store = (cnt_reg < CNT_W'(TABLE_DEPTH));
    assign seed_v     = (s_tdata[DATA_W-1:0] == '0) ? GEN_ONE_RESET : s_tdata[DATA_W-1:0];

    clsr_modmul u_gen_one (
        .aclk    (aclk),
        .sel_two (1'b0),
        .x       (g1_reg),
        .r       (r1)
    );

    clsr_modmul u_gen_two (
        .aclk    (aclk),
        .sel_two (1'b1),
        .x       (g2_reg),
        .r       (r2)
    );

    clsr_slot u_slot (
        .aclk        (aclk),
        .last_output (last_reg),
        .slot        (slot)
    );

    clsr_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .wdata   (tbl_wdata),
        .rdata   (entry)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_RMUL : ST_DMUL;
                end
            end
            ST_RMUL:   state_next = ST_RRED;
            ST_RRED:   state_next = warm_last ? ST_SETTLE : ST_RMUL;
            // let the slot compares register the new last output before the table read
            ST_SETTLE: state_next = ST_DMUL;
            ST_DMUL:   state_next = ST_DRED;
            ST_DRED:   state_next = ST_DOUT;
            ST_DOUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        s_tready      = 1'b0;
        ld_seed       = 1'b0;
        ld_g1_warm    = 1'b0;
        ld_g_draw     = 1'b0;
        ld_slot       = 1'b0;
        out_load      = 1'b0;
        tbl_ctrl      = '0;
        tbl_wdata     = g1_reg;
        case (state_reg)
            ST_IDLE: begin
                // take no beat while reset is held
                s_tready = aresetn;
                ld_seed  = in_fire && s_tuser;
            end
            ST_RRED: begin
                // warm-up step: store the last TABLE_DEPTH values, top slot first
                ld_g1_warm     = 1'b1;
                tbl_ctrl.wr_en = warm_store;
                tbl_ctrl.addr  = cnt_reg[SLOT_W-1:0];
                tbl_wdata      = r1;
            end
            ST_DMUL: begin
                tbl_ctrl.rd_en = 1'b1;
                tbl_ctrl.addr  = slot;
                ld_slot        = 1'b1;
            end
            ST_DRED: begin
                ld_g_draw = 1'b1;
            end
            ST_DOUT: begin
                // refill the slot just read with the new first generator value
                out_load       = out_free;
                tbl_ctrl.wr_en = out_free;
                tbl_ctrl.addr  = slot_reg;
                tbl_wdata      = g1_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Slot content minus second generator, wrapped into 1..WRAP_SPAN
    always_comb begin
        res_wrap = SUM_W'(entry) + SUM_W'(WRAP_SPAN) - SUM_W'(g2_reg);
        res      = (entry > g2_reg) ? entry - g2_reg : res_wrap[DATA_W-1:0];
        sat_v    = (res > SAT_LIMIT) ? SAT_LIMIT : res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            g1_reg      <= GEN_ONE_RESET;
            g2_reg      <= GEN_TWO_RESET;
            last_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ld_seed) begin
                g1_reg  <= seed_v;
                g2_reg  <= seed_v;
                cnt_reg <= CNT_W'(WARM_STEPS - 1);
            end
            if (ld_g1_warm) begin
                g1_reg <= r1;
                if (warm_last) begin
                    last_reg <= r1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            if (ld_g_draw) begin
                g1_reg <= r1;
                g2_reg <= r2;
            end
            if (out_load) begin
                last_reg    <= res;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (ld_slot) begin
            slot_reg <= slot;
        end
        if (out_load) begin
            m_data_reg <= sat_v;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

// File: rtl/clsr_checker.sv
// Port-level checker for the combined LCG shuffle RNG unit, bound to the top level.
// Depends on clsr_pkg and combined_lcg_shuffle_rng_unit_defines.svh.
`include "combined_lcg_shuffle_rng_unit_defines.svh"

module clsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import clsr_pkg::*;

    logic m_stall;
    logic s_beat;
    logic s_quiet;
    logic sample_ok;

    assign m_stall   = m_tvalid && !m_tready;
    assign s_beat    = s_tvalid && s_tready;
    assign s_quiet   = s_tready && !s_tvalid;
    assign sample_ok = !m_tdata[31] && (m_tdata[30:0] <= SAT_LIMIT);

    // a stalled result beat stays offered
    `CLSR_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_stall, m_tvalid, "stalled result beat dropped")
    // one item at a time: no second beat right after an accepted one
    `CLSR_ASSERT_NEXT(a_one_item, aclk, aresetn, s_beat, !s_tready, "input accepted while busy")
    // an idle cycle with no input beat offered is not followed by a rising result beat
    `CLSR_ASSERT_NEXT(a_no_ghost, aclk, aresetn, s_quiet, !$rose(m_tvalid), "ghost result beat")
    // samples are saturated and the pad bit is zero
    `CLSR_ASSERT_NOW(a_sat, aclk, aresetn, m_tvalid, sample_ok, "sample above saturation limit")

endmodule

bind combined_lcg_shuffle_rng_unit clsr_checker u_clsr_checker (.*);
